[rtl/igfr_pkg.sv]
`default_nettype none

package igfr_pkg;

  localparam int RING_SLOTS_DEF  = 16;
  localparam int MAX_PAYLOAD_DEF = 255;
  localparam int SLOT_STRIDE     = 256;
  localparam int SLOT_FIELD_W    = 8;
  localparam logic [7:0] IDLE_SAMPLES_RST = 8'd20;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BYTE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CK_PLAIN   = 2'd0,
    CK_BYTE_WR = 2'd1,
    CK_LEN_WR  = 2'd2,
    CK_READ    = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [7:0]              pos;
    logic [7:0]              wdata;
    logic                    pos_ok;
    logic                    frame_done;
    logic [3:0]              done_slot;
    logic [7:0]              done_length;
    logic                    byte_dropped;
    logic [3:0]              frames_waiting;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/idle_gap_frame_receiver_top.sv]
`default_nettype none

// channel  | dir | signals                                 | word
// s_axis   | in  | tvalid tready tdata[23:0] tuser[1:0]    | one event
// m_axis   | out | tvalid tready tdata[39:0]               | one result per event
// cfg      | in  | cfg_we_i cfg_wdata_i[7:0]               | idle_samples
//
// one word per cycle sustained while m_axis is ready; accepted input reaches
// the queue register, then the byte memory read register in the back end
// reset clears pointers, counters and the per-slot length valid bits at once,
// no clearing pass; frame byte storage holds garbage until written
// s_axis_tready drops only when the two-entry queue is full

module idle_gap_frame_receiver_top #(
  parameter int RING_SLOTS  = igfr_pkg::RING_SLOTS_DEF,
  parameter int MAX_PAYLOAD = igfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // line_level, rx_byte, read_slot, read_pos
  input  wire logic [23:0] s_axis_tdata,
  // op
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // frame_done, done_slot, done_length, byte_dropped, read_data,
  // read_frame_length, frames_waiting
  output logic [39:0]      m_axis_tdata
);
  import igfr_pkg::*;

  cmd_t front_cmd, q_cmd;
  logic q_full, q_valid, q_pop, accept;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  igfr_front #(
    .RING_SLOTS (RING_SLOTS),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .op_i        (s_axis_tuser),
    .line_level_i(s_axis_tdata[0]),
    .rx_byte_i   (s_axis_tdata[8:1]),
    .read_slot_i (s_axis_tdata[12:9]),
    .read_pos_i  (s_axis_tdata[20:13]),
    .cmd_o       (front_cmd)
  );

  igfr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .push_cmd_i(front_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_cmd_o (q_cmd)
  );

  igfr_back #(
    .RING_SLOTS(RING_SLOTS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_cmd_i  (q_cmd),
    .q_pop_o  (q_pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata)
  );

  a_done_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[13])
    else $error("commit word also flags a dropped byte");

  a_done_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[12:5] != 8'd0))
    else $error("committed frame with zero length");

  a_done_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[29:14] == 16'd0))
    else $error("commit word carries read data");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end pops an empty queue");

endmodule

`default_nettype wire

[rtl/igfr_front.sv]
`default_nettype none

module igfr_front #(
  parameter int RING_SLOTS  = igfr_pkg::RING_SLOTS_DEF,
  parameter int MAX_PAYLOAD = igfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  input  wire logic          accept_i,
  input  wire logic [1:0]    op_i,
  input  wire logic          line_level_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic [3:0]    read_slot_i,
  input  wire logic [7:0]    read_pos_i,
  output igfr_pkg::cmd_t     cmd_o
);
  import igfr_pkg::*;

  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  logic [7:0]        idle_samples_q;
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic [SLOT_W-1:0] release_slot_q, release_slot_d;
  logic [7:0]        open_len_q, open_len_d;
  logic [7:0]        idle_cnt_q, idle_cnt_d;

  logic [SLOT_W-1:0] write_next, release_next;
  logic [8:0]        waiting_now, waiting_new;
  logic [7:0]        need, idle_inc, byte_pos;
  logic [8:0]        write_ext, read_ext;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [8:0] waiting(input logic [SLOT_W-1:0] w,
                                         input logic [SLOT_W-1:0] r);
    waiting = (w >= r) ? (9'(w) - 9'(r)) : (9'(w) + 9'(RING_SLOTS) - 9'(r));
  endfunction

  always_comb begin
    write_next   = next_slot(write_slot_q);
    release_next = next_slot(release_slot_q);
    waiting_now  = waiting(write_slot_q, release_slot_q);
    need         = (idle_samples_q == 8'd0) ? 8'd1 : idle_samples_q;
    idle_inc     = (idle_cnt_q == 8'hff) ? idle_cnt_q : idle_cnt_q + 8'd1;
    byte_pos     = (open_len_q >= 8'(MAX_PAYLOAD)) ? 8'd0 : open_len_q;
    write_ext    = 9'(write_slot_q);
    read_ext     = 9'(read_slot_i);

    write_slot_d   = write_slot_q;
    release_slot_d = release_slot_q;
    open_len_d     = open_len_q;
    idle_cnt_d     = idle_cnt_q;

    cmd_o              = '0;
    cmd_o.kind         = CK_PLAIN;

    unique case (op_e'(op_i))
      OP_TICK: begin
        if (!line_level_i) begin
          idle_cnt_d = 8'd0;
        end else begin
          idle_cnt_d = idle_inc;
          if ((open_len_q != 8'd0) && (idle_inc >= need)) begin
            cmd_o.kind        = CK_LEN_WR;
            cmd_o.slot        = SLOT_FIELD_W'(write_slot_q);
            cmd_o.wdata       = open_len_q;
            cmd_o.frame_done  = 1'b1;
            cmd_o.done_slot   = write_ext[3:0];
            cmd_o.done_length = open_len_q;
            write_slot_d      = write_next;
            open_len_d        = 8'd0;
            idle_cnt_d        = 8'd0;
          end
        end
      end
      OP_BYTE: begin
        idle_cnt_d = 8'd0;
        if (write_next == release_slot_q) begin
          open_len_d         = 8'd0;
          cmd_o.byte_dropped = 1'b1;
        end else begin
          cmd_o.kind  = CK_BYTE_WR;
          cmd_o.slot  = SLOT_FIELD_W'(write_slot_q);
          cmd_o.pos   = byte_pos;
          cmd_o.wdata = rx_byte_i;
          open_len_d  = byte_pos + 8'd1;
        end
      end
      OP_RELEASE: begin
        if (waiting_now != 9'd0) begin
          release_slot_d = release_next;
        end
      end
      OP_READ: begin
        if (read_ext < 9'(RING_SLOTS)) begin
          cmd_o.kind   = CK_READ;
          cmd_o.slot   = SLOT_FIELD_W'(read_slot_i);
          cmd_o.pos    = read_pos_i;
          cmd_o.pos_ok = (read_pos_i < 8'(MAX_PAYLOAD));
        end
      end
      default: begin
      end
    endcase

    waiting_new          = waiting(write_slot_d, release_slot_d);
    cmd_o.frames_waiting = waiting_new[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_samples_q <= IDLE_SAMPLES_RST;
    end else if (cfg_we_i) begin
      idle_samples_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q   <= '0;
      release_slot_q <= '0;
      open_len_q     <= '0;
      idle_cnt_q     <= '0;
    end else if (accept_i) begin
      write_slot_q   <= write_slot_d;
      release_slot_q <= release_slot_d;
      open_len_q     <= open_len_d;
      idle_cnt_q     <= idle_cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/igfr_queue.sv]
`default_nettype none

module igfr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire igfr_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output igfr_pkg::cmd_t      pop_cmd_o
);
  import igfr_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  always_comb begin
    full_o    = (count_q == 2'd2);
    valid_o   = (count_q != 2'd0);
    pop_cmd_o = mem_q[rd_ptr_q];
    count_d   = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

[rtl/igfr_back.sv]
`default_nettype none

module igfr_back #(
  parameter int RING_SLOTS = igfr_pkg::RING_SLOTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire igfr_pkg::cmd_t q_cmd_i,
  output logic                q_pop_o,
  output logic                m_valid_o,
  input  wire logic           m_ready_i,
  output logic [39:0]         m_data_o
);
  import igfr_pkg::*;

  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int ADDR_W = SLOT_W + 8;
  localparam int DEPTH  = RING_SLOTS * SLOT_STRIDE;

  logic [7:0]            byte_mem [DEPTH];
  logic [7:0]            len_mem  [RING_SLOTS];
  logic [RING_SLOTS-1:0] len_vld_q;

  cmd_t        side_q;
  logic [7:0]  rd_byte_q, rd_len_q;
  logic        rd_lvld_q;
  logic        out_vld_q, out_vld_d;

  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        read_data, read_len;
  logic              is_read;

  always_comb begin
    slot      = q_cmd_i.slot[SLOT_W-1:0];
    addr      = {slot, q_cmd_i.pos};
    q_pop_o   = q_valid_i && (!out_vld_q || m_ready_i);
    out_vld_d = q_pop_o ? 1'b1 : (m_ready_i ? 1'b0 : out_vld_q);
    is_read   = (side_q.kind == CK_READ);
    read_data = (is_read && side_q.pos_ok) ? rd_byte_q : 8'd0;
    read_len  = (is_read && rd_lvld_q) ? rd_len_q : 8'd0;
    m_valid_o = out_vld_q;
    // frame_done, done_slot, done_length, byte_dropped, read_data,
    // read_frame_length, frames_waiting
    m_data_o  = {6'd0, side_q.frames_waiting, read_len, read_data,
                 side_q.byte_dropped, side_q.done_length, side_q.done_slot,
                 side_q.frame_done};
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && (q_cmd_i.kind == CK_BYTE_WR)) begin
      byte_mem[addr] <= q_cmd_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && (q_cmd_i.kind == CK_LEN_WR)) begin
      len_mem[slot] <= q_cmd_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      side_q <= q_cmd_i;
      if (q_cmd_i.kind == CK_READ) begin
        rd_byte_q <= byte_mem[addr];
        rd_len_q  <= len_mem[slot];
        rd_lvld_q <= len_vld_q[slot];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (q_pop_o && (q_cmd_i.kind == CK_LEN_WR)) begin
        len_vld_q[slot] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[verif/igfr_checker.sv]
`default_nettype none

module igfr_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,
  output int               fail_count_o,
  output int               pending_o,
  output logic [15:0][7:0] byte_span_o
);

  import igfr_pkg::*;

  // first member in the top bits, so the cast follows the tdata layout
  typedef struct packed {
    logic [3:0] frames_waiting;
    logic [7:0] read_frame_length;
    logic [7:0] read_data;
    logic       byte_dropped;
    logic [7:0] done_length;
    logic [3:0] done_slot;
    logic       frame_done;
  } frame_result_t;

  logic [7:0]       idle_samples;
  int unsigned      wr_slot;
  int unsigned      rel_slot;
  int unsigned      open_len;
  int unsigned      idle_cnt;
  logic [7:0]       frame_mem [RING_SLOTS_DEF*SLOT_STRIDE];
  logic [7:0]       len_mem [RING_SLOTS_DEF];
  logic [15:0][7:0] span;
  frame_result_t    expected_q [$];
  int               fails;

  function automatic int unsigned next_slot(int unsigned s);
    return (s + 1) % RING_SLOTS_DEF;
  endfunction

  function automatic frame_result_t receive_event(op_e op, logic lvl, logic [7:0] rx,
                                                  logic [3:0] rslot, logic [7:0] rpos);
    frame_result_t res;
    int unsigned   need;
    res = '0;
    case (op)
      OP_TICK: begin
        if (!lvl) begin
          idle_cnt = 0;
        end else begin
          need = (idle_samples == 8'd0) ? 1 : idle_samples;
          if (idle_cnt < 255) idle_cnt++;
          if (open_len > 0 && idle_cnt >= need) begin
            len_mem[wr_slot] = 8'(open_len);
            res.frame_done   = 1'b1;
            res.done_slot    = 4'(wr_slot);
            res.done_length  = 8'(open_len);
            wr_slot  = next_slot(wr_slot);
            open_len = 0;
            idle_cnt = 0;
          end
        end
      end
      OP_BYTE: begin
        idle_cnt = 0;
        if (next_slot(wr_slot) == rel_slot) begin
          open_len = 0;
          res.byte_dropped = 1'b1;
        end else begin
          if (open_len >= MAX_PAYLOAD_DEF) open_len = 0;
          frame_mem[wr_slot*SLOT_STRIDE + open_len] = rx;
          open_len++;
          if (open_len > span[wr_slot]) span[wr_slot] = 8'(open_len);
        end
      end
      OP_RELEASE: begin
        if (wr_slot != rel_slot) rel_slot = next_slot(rel_slot);
      end
      default: begin
        res.read_frame_length = len_mem[rslot];
        if (rpos < MAX_PAYLOAD_DEF) res.read_data = frame_mem[rslot*SLOT_STRIDE + rpos];
      end
    endcase
    res.frames_waiting = 4'((wr_slot + RING_SLOTS_DEF - rel_slot) % RING_SLOTS_DEF);
    return res;
  endfunction

  function automatic string show(frame_result_t r);
    return $sformatf("done %0b slot %0d len %0d drop %0b data %02h flen %0d wait %0d",
                     r.frame_done, r.done_slot, r.done_length, r.byte_dropped,
                     r.read_data, r.read_frame_length, r.frames_waiting);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t got;
    frame_result_t want;
    string         diff;
    if (!rst_ni) begin
      idle_samples = IDLE_SAMPLES_RST;
      wr_slot      = 0;
      rel_slot     = 0;
      open_len     = 0;
      idle_cnt     = 0;
      span         = '0;
      fails        = 0;
      for (int i = 0; i < RING_SLOTS_DEF; i++) len_mem[i] = 8'd0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      byte_span_o  <= '0;
    end else begin
      if (cfg_we_i) idle_samples = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got = frame_result_t'(m_axis_tdata[33:0]);
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word: %s", show(got));
        end else begin
          want = expected_q.pop_front();
          diff = "";
          if (got.frame_done !== want.frame_done) diff = {diff, " frame_done"};
          if (got.done_slot !== want.done_slot) diff = {diff, " done_slot"};
          if (got.done_length !== want.done_length) diff = {diff, " done_length"};
          if (got.byte_dropped !== want.byte_dropped) diff = {diff, " byte_dropped"};
          if (got.read_data !== want.read_data) diff = {diff, " read_data"};
          if (got.read_frame_length !== want.read_frame_length)
            diff = {diff, " read_frame_length"};
          if (got.frames_waiting !== want.frames_waiting) diff = {diff, " frames_waiting"};
          if (diff != "") begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch in%s", diff);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(receive_event(op_e'(s_axis_tuser), s_axis_tdata[0],
                                           s_axis_tdata[8:1], s_axis_tdata[12:9],
                                           s_axis_tdata[20:13]));
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
      byte_span_o  <= span;
    end
  end

endmodule

`default_nettype wire

[verif/tb_idle_gap_frame_receiver_top.sv]
`default_nettype none

module tb_idle_gap_frame_receiver_top;

  import igfr_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [7:0]       cfg_wdata_i = 8'd0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // line_level, rx_byte, read_slot, read_pos
  logic [23:0]      s_axis_tdata = 24'd0;
  // op
  logic [1:0]       s_axis_tuser = 2'd0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // frame_done, done_slot, done_length, byte_dropped, read_data,
  // read_frame_length, frames_waiting
  logic [39:0]      m_axis_tdata;

  int               fail_count;
  int               pending_words;
  logic [15:0][7:0] byte_span;

  int               words_sent = 0;
  int               stall_left = 0;
  logic             src_quiet = 1'b0;
  logic             sink_quiet = 1'b0;
  int               cur_need = 20;

  idle_gap_frame_receiver_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  igfr_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words),
    .byte_span_o   (byte_span)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      sink_quiet    <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) sink_quiet <= !sink_quiet;
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left    <= sink_quiet ? 0 : gap_len();
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_event(op_e op, logic lvl, logic [7:0] rx, logic [3:0] slot,
                            logic [7:0] pos);
    int gap;
    gap = src_quiet ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, pos, slot, rx, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic tick(logic lvl);
    push_event(OP_TICK, lvl, 8'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic rx_byte(logic [7:0] b);
    push_event(OP_BYTE, 1'($urandom), b, 4'($urandom), 8'($urandom));
  endtask

  // only positions already written in that slot, or the out of range one
  task automatic host_read();
    logic [3:0] slot;
    logic [7:0] pos;
    slot = 4'($urandom);
    if (byte_span[slot] == 8'd0 || $urandom_range(0, 7) == 0) pos = 8'd255;
    else pos = 8'($urandom_range(0, byte_span[slot] - 1));
    push_event(OP_READ, 1'($urandom), 8'($urandom), slot, pos);
  endtask

  task automatic send_frame(int n);
    repeat (n) rx_byte(8'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(0, cur_need)) tick(1'b1);
      tick(1'b0);
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(0, cur_need)) tick(1'b1);
    else repeat (cur_need + $urandom_range(0, 2)) tick(1'b1);
  endtask

  task automatic set_idle(logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_need = (value == 8'd0) ? 1 : value;
  endtask

  task automatic random_mix(int budget, int release_pct);
    int start;
    int r;
    int n;
    start = words_sent;
    while (words_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        src_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 49) == 0 && budget - (words_sent - start) > 300)
          n = $urandom_range(250, 262);
        else if ($urandom_range(0, 7) == 0) n = $urandom_range(9, 40);
        else n = $urandom_range(1, 8);
        send_frame(n);
      end else if (r < 50 + release_pct) begin
        repeat ($urandom_range(1, 3))
          push_event(OP_RELEASE, 1'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 4)) host_read();
      end else begin
        push_event(op_e'($urandom_range(0, 2)), 1'($urandom), 8'($urandom),
                   4'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold of 20, nothing stored yet
    push_event(OP_READ, 1'b0, 8'h00, 4'd0, 8'd255);
    push_event(OP_RELEASE, 1'b0, 8'h00, 4'd0, 8'd0);
    tick(1'b0);
    rx_byte(8'h00);
    rx_byte(8'hFF);
    rx_byte(8'hA5);
    tick(1'b1);
    tick(1'b1);
    tick(1'b0);
    rx_byte(8'h5A);
    repeat (20) tick(1'b1);
    for (int i = 0; i < 4; i++) push_event(OP_READ, 1'b1, 8'hFF, 4'd0, 8'(i));
    push_event(OP_READ, 1'b1, 8'hFF, 4'd15, 8'd255);
    push_event(OP_RELEASE, 1'b1, 8'hFF, 4'd15, 8'd255);
    push_event(OP_READ, 1'b0, 8'h00, 4'd0, 8'd3);
    random_mix(100, 20);

    // frame runs past the payload limit
    set_idle(8'd1);
    send_frame(258);
    random_mix(300, 20);

    // zero threshold, and the ring filled to overflow
    set_idle(8'd0);
    src_quiet = 1'b1;
    repeat (17) begin
      rx_byte(8'($urandom));
      tick(1'b1);
    end
    random_mix(100, 5);

    // idle count saturates with no frame open
    set_idle(8'd255);
    src_quiet = 1'b0;
    repeat (260) tick(1'b1);
    rx_byte(8'($urandom));
    rx_byte(8'($urandom));
    repeat (255) tick(1'b1);
    random_mix(150, 20);

    set_idle(8'($urandom_range(2, 30)));
    random_mix(200, 35);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
